// ===== rtl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by spq_cell and sorted_priority_queue.
`default_nettype none

package spq_pkg;

  localparam int unsigned DefaultQueueDepth = 64;
  localparam int unsigned PayloadW = 32;
  localparam int unsigned RankW = 16;

  localparam logic FuncInsert = 1'b0;
  localparam logic FuncRemove = 1'b1;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } status_e;

  // One stored entry as it moves between neighboring cells.
  typedef struct packed {
    logic [RankW-1:0]    rank;
    logic [PayloadW-1:0] payload;
  } entry_t;

  // Operation broadcast to every cell in the chain.
  typedef struct packed {
    logic                ins;
    logic                rem;
    logic [RankW-1:0]    rank;
    logic [PayloadW-1:0] payload;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/spq_cell.sv =====
// One cell of the sorted queue chain: holds one entry and trades it with neighbors.
// Depends on spq_pkg.
`default_nettype none

module spq_cell (
  input  wire logic          clk_i,
  input  wire spq_pkg::cmd_t cmd_i,
  input  wire logic          valid_i,
  input  wire logic          left_shift_i,
  input  wire spq_pkg::entry_t left_i,
  input  wire spq_pkg::entry_t right_i,
  output logic               shift_o,
  output spq_pkg::entry_t    entry_o
);
  import spq_pkg::*;

  entry_t entry_q;
  entry_t entry_d;

  // A valid entry with a strictly larger rank makes room for the new one,
  // which keeps equal ranks in arrival order.
  assign shift_o = valid_i && (entry_q.rank > cmd_i.rank);

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins) begin
      if (shift_o || !valid_i) begin
        if (left_shift_i) begin
          entry_d = left_i;
        end else begin
          entry_d.rank    = cmd_i.rank;
          entry_d.payload = cmd_i.payload;
        end
      end
    end else if (cmd_i.rem) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

// ===== rtl/sorted_priority_queue.sv =====
// Sorted priority queue: a chain of spq_cell instances plus occupancy and result logic.
// Depends on spq_pkg and spq_cell.
// The result strobe done_o rises in the cycle after the transaction is accepted.
// Throughput: one transaction per cycle; busy_o stays low, since every cell updates at once.
// Reset: rst_ni asynchronously clears the occupancy, the status and the result strobe; entries need none.
// The receiver cannot stall, so each result is shown for exactly one cycle.
`default_nettype none

module sorted_priority_queue #(
  parameter int unsigned QueueDepth = spq_pkg::DefaultQueueDepth
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  output logic                                busy_o,
  input  wire logic                           func_i,
  input  wire logic signed [spq_pkg::PayloadW-1:0] payload_i,
  input  wire logic [spq_pkg::RankW-1:0]      rank_i,
  output logic                                done_o,
  output logic signed [spq_pkg::PayloadW-1:0] head_payload_o,
  output logic                                empty_res_o,
  output logic [1:0]                          status_o
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QueueDepth);

  logic [CntW-1:0] count_q, count_d;
  logic            done_q;
  status_e         status_q, status_d;

  logic   accept;
  logic   is_full, is_empty;
  cmd_t   cmd;
  logic   shift [QueueDepth];
  entry_t entry [QueueDepth];

  assign busy_o   = 1'b0;
  assign accept   = start_i && !busy_o;
  assign is_full  = (count_q == CntFull);
  assign is_empty = (count_q == '0);

  assign cmd.ins     = accept && (func_i == FuncInsert) && !is_full;
  assign cmd.rem     = accept && (func_i == FuncRemove) && !is_empty;
  assign cmd.rank    = rank_i;
  assign cmd.payload = payload_i;

  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    logic   valid;
    logic   left_shift;
    entry_t left_e, right_e;

    assign valid = (CntW'(i) < count_q);
    if (i == 0) begin : g_first
      assign left_shift = 1'b0;
      assign left_e     = entry[0];
    end else begin : g_mid
      assign left_shift = shift[i-1];
      assign left_e     = entry[i-1];
    end
    if (i == QueueDepth - 1) begin : g_last
      assign right_e = entry[i];
    end else begin : g_notlast
      assign right_e = entry[i+1];
    end

    spq_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .valid_i     (valid),
      .left_shift_i(left_shift),
      .left_i      (left_e),
      .right_i     (right_e),
      .shift_o     (shift[i]),
      .entry_o     (entry[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = StOk;
    if (accept) begin
      if (func_i == FuncInsert) begin
        if (is_full) begin
          status_d = StFull;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end else begin
        if (is_empty) begin
          status_d = StEmpty;
        end else begin
          count_d = count_q - CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      done_q   <= 1'b0;
      status_q <= StOk;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
      if (accept) begin
        status_q <= status_d;
      end
    end
  end

  assign done_o         = done_q;
  assign empty_res_o    = is_empty;
  assign status_o       = status_q;
  assign head_payload_o = is_empty ? '0 : entry[0].payload;

`ifndef ASSERT_OFF
  a_done_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("result strobe missing after accepted transaction");

  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !done_o)
    else $error("result strobe without accepted transaction");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("occupancy beyond queue depth");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == StFull) |-> is_full)
    else $error("full status reported on a queue that is not full");

  a_remove_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rem |=> (count_q == $past(count_q) - CntW'(1)))
    else $error("occupancy did not drop after remove");

  a_head_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CntW'(2)) |-> (entry[0].rank <= entry[1].rank))
    else $error("head entry out of rank order");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for sorted_priority_queue: a directed table, then random bursts.
// Results are checked against an in-bench sorted-list predictor. Depends on spq_pkg and the RTL.

module tb_top;
  import spq_pkg::*;

  localparam int unsigned QDepth = DefaultQueueDepth;
  localparam int unsigned RandomTxns = 950;
  localparam int unsigned CycleLimit = 40000;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned NumDirected = 20;

  typedef struct packed {
    logic signed [PayloadW-1:0] head;
    logic                       empty;
    status_e                    status;
  } result_t;

  typedef struct packed {
    logic                       func;
    logic signed [PayloadW-1:0] payload;
    logic [RankW-1:0]           rank;
    logic                       typed;
    result_t                    res;
  } stim_row_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start_i;
  logic                       busy_o;
  logic                       func_i;
  logic signed [PayloadW-1:0] payload_i;
  logic [RankW-1:0]           rank_i;
  logic                       done_o;
  logic signed [PayloadW-1:0] head_payload_o;
  logic                       empty_res_o;
  logic [1:0]                 status_o;

  // Predictor copy of the queue contents, kept in ascending rank order.
  logic [PayloadW-1:0] sorted_payload [QDepth];
  logic [RankW-1:0]    sorted_rank [QDepth];
  int unsigned         fill_level = 0;

  result_t     pending_results[$];
  stim_row_t   directed_tbl [NumDirected];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit          gaps_on = 1'b1;

  sorted_priority_queue dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .func_i        (func_i),
    .payload_i     (payload_i),
    .rank_i        (rank_i),
    .done_o        (done_o),
    .head_payload_o(head_payload_o),
    .empty_res_o   (empty_res_o),
    .status_o      (status_o)
  );

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic result_t queue_step(logic f, logic [PayloadW-1:0] p, logic [RankW-1:0] r);
    result_t     res;
    int unsigned pos;
    res.status = StOk;
    if (f == FuncInsert) begin
      if (fill_level >= QDepth) begin
        res.status = StFull;
      end else begin
        // A new entry goes behind every entry of equal or smaller rank.
        pos = 0;
        while (pos < fill_level && sorted_rank[pos] <= r) pos++;
        for (int unsigned i = fill_level; i > pos; i--) begin
          sorted_payload[i] = sorted_payload[i-1];
          sorted_rank[i] = sorted_rank[i-1];
        end
        sorted_payload[pos] = p;
        sorted_rank[pos] = r;
        fill_level++;
      end
    end else if (fill_level == 0) begin
      res.status = StEmpty;
    end else begin
      for (int unsigned i = 0; i + 1 < fill_level; i++) begin
        sorted_payload[i] = sorted_payload[i+1];
        sorted_rank[i] = sorted_rank[i+1];
      end
      fill_level--;
    end
    res.empty = (fill_level == 0);
    res.head = res.empty ? '0 : sorted_payload[0];
    return res;
  endfunction

  task automatic send_txn(input logic f, input logic signed [PayloadW-1:0] p,
                          input logic [RankW-1:0] r, input logic typed, input result_t typed_res);
    result_t predicted;
    @(negedge clk_i);
    while (gaps_on && $urandom_range(0, 99) < 23) begin
      start_i <= 1'b0;
      payload_i <= $urandom;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    func_i <= f;
    payload_i <= p;
    rank_i <= r;
    do @(posedge clk_i); while (busy_o);
    predicted = queue_step(f, p, r);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic wait_for_drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && done_o) begin
      got.head = head_payload_o;
      got.empty = empty_res_o;
      got.status = status_e'(status_o);
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected result: head %0d empty %0b status %0d",
                   got.head, got.empty, got.status);
      end else begin
        want = pending_results.pop_front();
        if (got.head !== want.head || got.empty !== want.empty || got.status !== want.status) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display({"mismatch: expected head %0d empty %0b status %0d, ",
                      "got head %0d empty %0b status %0d"},
                     want.head, want.empty, want.status, got.head, got.empty, got.status);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int unsigned sent;
    int unsigned burst_left;
    int unsigned insert_pct;
    logic        f;
    logic [RankW-1:0] r;
    rst_ni = 1'b0;
    start_i = 1'b0;
    func_i = FuncInsert;
    payload_i = '0;
    rank_i = '0;
    sent = 0;
    burst_left = 0;
    insert_pct = 50;

    // Typed rows hold the obvious answers; the rest go through the predictor.
    directed_tbl = '{
      '{FuncRemove, 32'sd0,            16'd0,      1'b1, '{32'sd0, 1'b1, StEmpty}},
      '{FuncInsert, 32'sh7FFFFFFF,     16'hFFFF,   1'b1, '{32'sh7FFFFFFF, 1'b0, StOk}},
      '{FuncInsert, 32'sh80000000,     16'h0000,   1'b1, '{32'sh80000000, 1'b0, StOk}},
      '{FuncInsert, 32'sd1,            16'h0000,   1'b0, '0},
      '{FuncInsert, -32'sd1,           16'h8000,   1'b0, '0},
      '{FuncInsert, 32'sd0,            16'hFFFF,   1'b0, '0},
      '{FuncInsert, 32'sh55555555,     16'h0001,   1'b0, '0},
      '{FuncInsert, 32'shAAAAAAAA,     16'hFFFE,   1'b0, '0},
      '{FuncRemove, 32'sd0,            16'd0,      1'b0, '0},
      '{FuncRemove, 32'shFFFFFFFF,     16'hFFFF,   1'b0, '0},
      '{FuncRemove, 32'sd0,            16'd0,      1'b0, '0},
      '{FuncRemove, 32'sd0,            16'd0,      1'b0, '0},
      '{FuncRemove, 32'sd0,            16'd0,      1'b0, '0},
      '{FuncRemove, 32'sd0,            16'd0,      1'b0, '0},
      '{FuncRemove, 32'sd0,            16'd0,      1'b0, '0},
      '{FuncRemove, 32'sd0,            16'd0,      1'b1, '{32'sd0, 1'b1, StEmpty}},
      '{FuncInsert, 32'sh12345678,     16'h5A5A,   1'b0, '0},
      '{FuncRemove, 32'shDEADBEEF,     16'hFFFF,   1'b0, '0},
      '{FuncInsert, 32'sd42,           16'd7,      1'b0, '0},
      '{FuncInsert, -32'sd42,          16'd6,      1'b0, '0}
    };

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_tbl[k])
      send_txn(directed_tbl[k].func, directed_tbl[k].payload, directed_tbl[k].rank,
               directed_tbl[k].typed, directed_tbl[k].res);
    wait_for_drain();

    // Bursts lean toward inserts or removes so the queue swings between full and empty.
    while (sent < RandomTxns) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(20, 120);
        case ($urandom_range(0, 2))
          0: insert_pct = 85;
          1: insert_pct = 15;
          default: insert_pct = 50;
        endcase
        if ($urandom_range(0, 9) == 0) wait_for_drain();
      end
      gaps_on = !(sent >= 400 && sent < 600);
      f = ($urandom_range(0, 99) < insert_pct) ? FuncInsert : FuncRemove;
      // Narrow ranks produce many ties, which exercise arrival order among equals.
      case ($urandom_range(0, 3))
        0: r = RankW'($urandom_range(0, 3));
        1: r = $urandom_range(0, 1) ? '1 : '0;
        default: r = RankW'($urandom_range(0, 65535));
      endcase
      send_txn(f, $urandom, r, 1'b0, '0);
      sent++;
      burst_left--;
    end

    wait_for_drain();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
